FILE: design/imu_pkg.sv
`default_nettype none

package imu_pkg;

    // Frame layout
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned WORD_W      = 16;
    localparam int unsigned SUM_W       = WORD_W + 2;
    localparam int unsigned PAYLOAD_LEN = 22;
    localparam int unsigned WORD_CNT    = PAYLOAD_LEN / 2;
    localparam int unsigned CELL_CNT    = PAYLOAD_LEN - 1;
    localparam int unsigned IDX_W       = $clog2(PAYLOAD_LEN);

    localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hA5;
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(PAYLOAD_LEN - 1);

    // Word positions inside the payload
    localparam int unsigned W_ACCEL_X = 0;
    localparam int unsigned W_ACCEL_Y = 1;
    localparam int unsigned W_ACCEL_Z = 2;
    localparam int unsigned W_RATE_X  = 3;
    localparam int unsigned W_RATE_Y  = 4;
    localparam int unsigned W_RATE_Z  = 5;
    localparam int unsigned W_YAW     = 6;
    localparam int unsigned W_PITCH   = 7;
    localparam int unsigned W_ROLL    = 8;
    localparam int unsigned W_TEMP    = 9;
    localparam int unsigned W_CHECK   = 10;

    // Header hunt / frame collection states
    typedef enum logic [1:0] {
        ST_HUNT,
        ST_HDR,
        ST_FRAME
    } imu_state_t;

    // Control from the frame sequencer to the datapath
    typedef struct packed {
        logic shift_en;    // payload byte goes into the cell row
        logic last_slot;   // next payload byte closes the frame
        logic frame_done;  // closing byte accepted this cycle
    } imu_ctrl_t;

endpackage

`default_nettype wire

FILE: design/imu_byte_if.sv
`default_nettype none

interface imu_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: design/imu_frame_if.sv
`default_nettype none

interface imu_frame_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [15:0] yaw_raw;
    logic signed [15:0] pitch_raw;
    logic signed [15:0] roll_raw;
    logic signed [15:0] temp_raw;

    modport source (
        output valid, input ready,
        output accel_x, output accel_y, output accel_z,
        output rate_x, output rate_y, output rate_z,
        output yaw_raw, output pitch_raw, output roll_raw, output temp_raw
    );
    modport sink (
        input valid, output ready,
        input accel_x, input accel_y, input accel_z,
        input rate_x, input rate_y, input rate_z,
        input yaw_raw, input pitch_raw, input roll_raw, input temp_raw
    );
endinterface

`default_nettype wire

FILE: design/imu_byte_cell.sv
`default_nettype none

// One payload byte slot; takes its neighbor's byte on each shift.
module imu_byte_cell (
    input  wire logic                       clk,
    input  wire logic                       shift_en,
    input  wire logic [imu_pkg::BYTE_W-1:0] d,
    output logic      [imu_pkg::BYTE_W-1:0] q
);

    logic [imu_pkg::BYTE_W-1:0] data_reg;
    logic [imu_pkg::BYTE_W-1:0] data_next;

    // hold unless a payload byte moves down the row
    always_comb
    begin
        data_next = shift_en ? d : data_reg;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

`default_nettype wire

FILE: design/imu_frame_ctrl.sv
`default_nettype none

// Header hunt and payload slot counter.
module imu_frame_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       accept,
    input  wire logic [imu_pkg::BYTE_W-1:0] rx_byte,
    output imu_pkg::imu_ctrl_t              ctrl
);

    imu_pkg::imu_state_t          state_reg;
    imu_pkg::imu_state_t          state_next;
    logic [imu_pkg::IDX_W-1:0]    idx_reg;
    logic [imu_pkg::IDX_W-1:0]    idx_next;
    logic                         is_hdr;
    logic                         at_last;

    assign is_hdr  = (rx_byte == imu_pkg::HDR_BYTE);
    assign at_last = (idx_reg == imu_pkg::LAST_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= imu_pkg::ST_HUNT;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        ctrl.shift_en   = 1'b0;
        ctrl.last_slot  = 1'b0;
        ctrl.frame_done = 1'b0;
        unique case (state_reg)
            imu_pkg::ST_HUNT:
            begin
                if (accept && is_hdr)
                begin
                    state_next = imu_pkg::ST_HDR;
                end
            end
            imu_pkg::ST_HDR:
            begin
                if (accept)
                begin
                    // second header byte opens a frame, anything else restarts
                    state_next = is_hdr ? imu_pkg::ST_FRAME : imu_pkg::ST_HUNT;
                    idx_next   = '0;
                end
            end
            imu_pkg::ST_FRAME:
            begin
                ctrl.last_slot = at_last;
                if (accept)
                begin
                    if (at_last)
                    begin
                        ctrl.frame_done = 1'b1;
                        state_next      = imu_pkg::ST_HUNT;
                        idx_next        = '0;
                    end
                    else
                    begin
                        ctrl.shift_en = 1'b1;
                        idx_next      = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = imu_pkg::ST_HUNT;
                idx_next   = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/imu_serial_frame_deframer.sv
`default_nettype none

// Channel   Dir  Payload                                  Notes
// rx        in   rx_byte[7:0]                             one serial byte per request
// frame     out  accel/rate x,y,z, yaw, pitch, roll, temp one request per good frame
//
// One byte is taken per ready cycle; the payload moves down a row of 21 byte cells
// and the 22nd byte is used straight from the input when the check is made.
// A good frame appears in the output register the cycle after its last byte.
// rx stalls only on a closing byte while the previous frame is still unread.
// Reset returns to header hunting; cell contents are not cleared.
module imu_serial_frame_deframer (
    input  wire logic  clk,
    input  wire logic  rst_n,
    imu_byte_if.sink   rx,
    imu_frame_if.source frame
);

    localparam int unsigned BW = imu_pkg::BYTE_W;
    localparam int unsigned WW = imu_pkg::WORD_W;
    localparam int unsigned SW = imu_pkg::SUM_W;

    imu_pkg::imu_ctrl_t     ctrl;
    logic                   accept;
    logic [BW-1:0]          cell_q [imu_pkg::CELL_CNT];
    logic [BW-1:0]          pl_byte [imu_pkg::PAYLOAD_LEN];
    logic signed [WW-1:0]   word [imu_pkg::WORD_CNT];
    logic signed [SW-1:0]   angle_sum;
    logic signed [SW-1:0]   check_ext;
    logic                   check_ok;
    logic                   good;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic signed [WW-1:0]   out_word_reg [imu_pkg::W_CHECK];

    assign accept   = rx.valid && rx.ready;
    // a finished frame may only be blocked by an unread previous one
    assign rx.ready = !(ctrl.last_slot && out_valid_reg && !frame.ready);

    imu_frame_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx.rx_byte),
        .ctrl    (ctrl)
    );

    // payload cell row: newest byte enters cell 0
    for (genvar gi = 0; gi < imu_pkg::CELL_CNT; gi++)
    begin : g_cell
        logic [BW-1:0] cell_d;
        if (gi == 0)
        begin : g_head
            assign cell_d = rx.rx_byte;
        end
        else
        begin : g_body
            assign cell_d = cell_q[gi-1];
        end
        imu_byte_cell u_cell (
            .clk      (clk),
            .shift_en (ctrl.shift_en),
            .d        (cell_d),
            .q        (cell_q[gi])
        );
    end

    // payload byte j sits in cell (20 - j); the last byte is still on the input
    for (genvar gj = 0; gj < imu_pkg::CELL_CNT; gj++)
    begin : g_byte
        assign pl_byte[gj] = cell_q[imu_pkg::CELL_CNT-1-gj];
    end
    assign pl_byte[imu_pkg::PAYLOAD_LEN-1] = rx.rx_byte;

    // little-endian words
    for (genvar gw = 0; gw < imu_pkg::WORD_CNT; gw++)
    begin : g_word
        assign word[gw] = {pl_byte[2*gw+1], pl_byte[2*gw]};
    end

    // check word against exact sum of rate z and the three angles
    assign angle_sum = {{2{word[imu_pkg::W_RATE_Z][WW-1]}}, word[imu_pkg::W_RATE_Z]}
                     + {{2{word[imu_pkg::W_YAW][WW-1]}},    word[imu_pkg::W_YAW]}
                     + {{2{word[imu_pkg::W_PITCH][WW-1]}},  word[imu_pkg::W_PITCH]}
                     + {{2{word[imu_pkg::W_ROLL][WW-1]}},   word[imu_pkg::W_ROLL]};
    assign check_ext = {{2{word[imu_pkg::W_CHECK][WW-1]}}, word[imu_pkg::W_CHECK]};
    assign check_ok  = (angle_sum == check_ext);
    assign good      = ctrl.frame_done && check_ok;

    // output register
    always_comb
    begin
        priority if (good)
        begin
            out_valid_next = 1'b1;
        end
        else if (frame.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (good)
        begin
            for (int k = 0; k < imu_pkg::W_CHECK; k++)
            begin
                out_word_reg[k] <= word[k];
            end
        end
    end

    assign frame.valid     = out_valid_reg;
    assign frame.accel_x   = out_word_reg[imu_pkg::W_ACCEL_X];
    assign frame.accel_y   = out_word_reg[imu_pkg::W_ACCEL_Y];
    assign frame.accel_z   = out_word_reg[imu_pkg::W_ACCEL_Z];
    assign frame.rate_x    = out_word_reg[imu_pkg::W_RATE_X];
    assign frame.rate_y    = out_word_reg[imu_pkg::W_RATE_Y];
    assign frame.rate_z    = out_word_reg[imu_pkg::W_RATE_Z];
    assign frame.yaw_raw   = out_word_reg[imu_pkg::W_YAW];
    assign frame.pitch_raw = out_word_reg[imu_pkg::W_PITCH];
    assign frame.roll_raw  = out_word_reg[imu_pkg::W_ROLL];
    assign frame.temp_raw  = out_word_reg[imu_pkg::W_TEMP];

    // a new result only follows a closing byte
    a_rise_after_close: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(frame.valid) |-> $past(ctrl.frame_done))
        else $error("result appeared without a closed frame");

    // a good frame is always presented next cycle
    a_good_shown: assert property (@(posedge clk) disable iff (!rst_n)
        good |=> frame.valid)
        else $error("good frame lost");

    // closing byte never accepted over an unread result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.last_slot && frame.valid && !frame.ready) |-> !rx.ready)
        else $error("closing byte accepted while result stalled");

    // shifting and closing are exclusive
    a_shift_close: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.shift_en && ctrl.frame_done))
        else $error("shift and close in the same cycle");

endmodule

`default_nettype wire
